// ----- rtl/bpc_pkg.sv -----
// Shared constants and helpers for the barometric pressure compensation block.
// No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;

    // Compensation constants
    localparam logic [31:0] K_B6_OFS   = 32'd4000;
    localparam logic [31:0] K_X3_OFS   = 32'd32768;
    localparam logic [31:0] K_B7_MUL   = 32'd50000;
    localparam logic [31:0] K_P_SQ_MUL = 32'd3038;
    localparam logic [31:0] K_P_LIN    = -32'sd7357;
    localparam logic [31:0] K_P_OFS    = 32'd3791;
    localparam logic signed [31:0] T_MAX = 32'sd32767;
    localparam logic signed [31:0] T_MIN = -32'sd32768;
    localparam logic signed [31:0] P_MAX = 32'sd131071;

    // Sign-extend a 16-bit calibration half-word
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Arithmetic right shift of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bpc_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on bpc_pkg; carries a sideband word alongside each beat.
`default_nettype none

module bpc_div
    import bpc_pkg::*;
#(
    parameter int unsigned W    = WORD_W,
    parameter int unsigned SB_W = 1
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [W-1:0]    num,
    input  wire logic [W-1:0]    den,
    input  wire logic [SB_W-1:0] sb_in,
    output logic                 out_valid,
    output logic [W-1:0]         quo,
    output logic [SB_W-1:0]      sb_out
);

    logic            v_reg  [1:W];
    logic [W-1:0]    r_reg  [1:W];
    logic [W-1:0]    q_reg  [1:W];
    logic [W-1:0]    d_reg  [1:W];
    logic [SB_W-1:0] sb_reg [1:W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic            v_src;
        logic [W-1:0]    r_src;
        logic [W-1:0]    q_src;
        logic [W-1:0]    d_src;
        logic [SB_W-1:0] sb_src;
        logic [W:0]      trial;
        logic [W:0]      diff;
        logic [W-1:0]    r_next;
        logic [W-1:0]    q_next;

        if (i == 0) begin : g_first
            assign v_src  = in_valid;
            assign r_src  = '0;
            assign q_src  = num;
            assign d_src  = den;
            assign sb_src = sb_in;
        end
        else begin : g_rest
            assign v_src  = v_reg[i];
            assign r_src  = r_reg[i];
            assign q_src  = q_reg[i];
            assign d_src  = d_reg[i];
            assign sb_src = sb_reg[i];
        end

        // Shift in the next numerator bit and try to subtract the divisor
        always_comb
        begin
            trial = {r_src, q_src[W-1]};
            diff  = trial - {1'b0, d_src};
            if (!diff[W])
            begin
                r_next = diff[W-1:0];
                q_next = {q_src[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_src[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1]  <= r_next;
                q_reg[i+1]  <= q_next;
                d_reg[i+1]  <= d_src;
                sb_reg[i+1] <= sb_src;
            end
        end
    end

    assign out_valid = v_reg[W];
    assign quo       = q_reg[W];
    assign sb_out    = sb_reg[W];

endmodule

`default_nettype wire

// ----- rtl/barometric_pressure_compensation.sv -----
// Pipeline: 20 arithmetic stages plus two 32-stage dividers and the output register.
// Throughput: one beat per cycle; every stage, both dividers included, takes a new
// beat each cycle and the whole pipe holds while the output beat waits.
// Reset: rst_n clears all valid bits and the calibration registers to zero.
// Top level of the barometric pressure compensation block; uses bpc_pkg and bpc_div.
`default_nettype none

module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [15:0] raw_temperature, [31:16] raw_pressure
    input  wire logic [31:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [15:0] temperature_tenths, [32:16] pressure_pa, [39:33] zero
    output logic [39:0]               m_tdata,
    // [0] fault
    output logic [0:0]                m_tuser
);

    localparam int unsigned SB1_W = 32 + 16 + 2;
    localparam int unsigned SB2_W = 16 + 2;

    // ---------------- calibration registers ----------------
    logic [31:0] cal0_reg, cal1_reg, cal2_reg, cal3_reg, cal4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal0_reg <= '0;
            cal1_reg <= '0;
            cal2_reg <= '0;
            cal3_reg <= '0;
            cal4_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AC1_AC2: cal0_reg <= cfg_data;
                REG_AC3_AC4: cal1_reg <= cfg_data;
                REG_AC5_AC6: cal2_reg <= cfg_data;
                REG_B1_B2:   cal3_reg <= cfg_data;
                REG_MC_MD:   cal4_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(cal0_reg[31:16]);
    assign ac2 = sx16(cal0_reg[15:0]);
    assign ac3 = sx16(cal1_reg[31:16]);
    assign ac4 = {16'd0, cal1_reg[15:0]};
    assign ac5 = {16'd0, cal2_reg[31:16]};
    assign ac6 = {16'd0, cal2_reg[15:0]};
    assign b1  = sx16(cal3_reg[31:16]);
    assign b2  = sx16(cal3_reg[15:0]);
    assign mc  = sx16(cal4_reg[31:16]);
    assign md  = sx16(cal4_reg[15:0]);

    // Whole pipe advances unless the output beat is stalled
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- temperature front ----------------
    logic        a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic [31:0] a_d_reg, b_m_reg, c_x1_reg, c_div_reg, d_x1_reg, d_na_reg, d_da_reg;
    logic [15:0] a_up_reg, b_up_reg, c_up_reg, d_up_reg;
    logic        d_fz_reg, d_neg_reg;
    logic [31:0] mc_num;
    assign mc_num = {mc[20:0], 11'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // offset raw temperature
            a_d_reg   <= {16'd0, s_tdata[15:0]} - ac6;
            a_up_reg  <= s_tdata[31:16];
            // scale by ac5
            b_m_reg   <= a_d_reg * ac5;
            b_up_reg  <= a_up_reg;
            // X1 and the divisor
            c_x1_reg  <= asr(b_m_reg, 15);
            c_div_reg <= asr(b_m_reg, 15) + md;
            c_up_reg  <= b_up_reg;
            // magnitudes for the signed divide
            d_na_reg  <= mc_num[31] ? (32'd0 - mc_num) : mc_num;
            d_da_reg  <= c_div_reg[31] ? (32'd0 - c_div_reg) : c_div_reg;
            d_neg_reg <= mc_num[31] ^ c_div_reg[31];
            d_fz_reg  <= (c_div_reg == 32'd0);
            d_x1_reg  <= c_x1_reg;
            d_up_reg  <= c_up_reg;
        end
    end

    logic             dv1_valid;
    logic [31:0]      dv1_quo;
    logic [SB1_W-1:0] dv1_sb;

    bpc_div #(.W(WORD_W), .SB_W(SB1_W)) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_v_reg),
        .num      (d_na_reg),
        .den      (d_da_reg),
        .sb_in    ({d_x1_reg, d_up_reg, d_fz_reg, d_neg_reg}),
        .out_valid(dv1_valid),
        .quo      (dv1_quo),
        .sb_out   (dv1_sb)
    );

    logic [31:0] dv1_x1;
    logic [15:0] dv1_up;
    logic        dv1_fz, dv1_neg;
    assign {dv1_x1, dv1_up, dv1_fz, dv1_neg} = dv1_sb;

    // ---------------- pressure coefficients ----------------
    logic e_v_reg, f_v_reg, g_v_reg, h_v_reg, i_v_reg, j_v_reg, k_v_reg, l_v_reg;
    logic m_v_reg, n_v_reg;
    logic [31:0] e_b5_reg, f_b6_reg, f_t_reg;
    logic [31:0] g_sq_reg, g_a2_reg, g_a3_reg;
    logic [31:0] h_b6sq_reg, h_x2a_reg, h_x1c_reg;
    logic [31:0] i_pb2_reg, i_pb1_reg, i_x2a_reg, i_x1c_reg;
    logic [31:0] j_b3n_reg, j_x3s_reg, k_b3_reg, k_x3p_reg;
    logic [31:0] l_b4p_reg, l_diff_reg, m_b4_reg, m_b7_reg;
    logic [31:0] n_num_reg, n_b4_reg;
    logic        n_dbl_reg;
    logic [15:0] g_t_reg, h_t_reg, i_t_reg, j_t_reg, k_t_reg, l_t_reg, m_t_reg, n_t_reg;
    logic [15:0] e_up_reg, f_up_reg, g_up_reg, h_up_reg, i_up_reg, j_up_reg, k_up_reg;
    logic e_flt_reg, f_flt_reg, g_flt_reg, h_flt_reg, i_flt_reg, j_flt_reg, k_flt_reg;
    logic l_flt_reg, m_flt_reg, n_flt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0; f_v_reg <= 1'b0; g_v_reg <= 1'b0; h_v_reg <= 1'b0;
            i_v_reg <= 1'b0; j_v_reg <= 1'b0; k_v_reg <= 1'b0; l_v_reg <= 1'b0;
            m_v_reg <= 1'b0; n_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= dv1_valid;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            j_v_reg <= i_v_reg;
            k_v_reg <= j_v_reg;
            l_v_reg <= k_v_reg;
            m_v_reg <= l_v_reg;
            n_v_reg <= m_v_reg;
        end
    end

    logic [31:0] b3_sum;
    assign b3_sum = j_b3n_reg + (j_b3n_reg[31] ? 32'd3 : 32'd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // B5 from signed quotient
            e_b5_reg   <= dv1_x1 + (dv1_neg ? (32'd0 - dv1_quo) : dv1_quo);
            e_up_reg   <= dv1_up;
            e_flt_reg  <= dv1_fz;
            // B6 and temperature
            f_b6_reg   <= e_b5_reg - K_B6_OFS;
            f_t_reg    <= asr(e_b5_reg + 32'd8, 4);
            f_up_reg   <= e_up_reg;
            f_flt_reg  <= e_flt_reg;
            // B6 products, saturate temperature
            g_sq_reg   <= f_b6_reg * f_b6_reg;
            g_a2_reg   <= ac2 * f_b6_reg;
            g_a3_reg   <= ac3 * f_b6_reg;
            if ($signed(f_t_reg) > T_MAX)
                g_t_reg <= T_MAX[15:0];
            else if ($signed(f_t_reg) < T_MIN)
                g_t_reg <= T_MIN[15:0];
            else
                g_t_reg <= f_t_reg[15:0];
            g_up_reg   <= f_up_reg;
            g_flt_reg  <= f_flt_reg;
            // scale products
            h_b6sq_reg <= asr(g_sq_reg, 12);
            h_x2a_reg  <= asr(g_a2_reg, 11);
            h_x1c_reg  <= asr(g_a3_reg, 13);
            h_t_reg    <= g_t_reg;
            h_up_reg   <= g_up_reg;
            h_flt_reg  <= g_flt_reg;
            // B6 squared products
            i_pb2_reg  <= b2 * h_b6sq_reg;
            i_pb1_reg  <= b1 * h_b6sq_reg;
            i_x2a_reg  <= h_x2a_reg;
            i_x1c_reg  <= h_x1c_reg;
            i_t_reg    <= h_t_reg;
            i_up_reg   <= h_up_reg;
            i_flt_reg  <= h_flt_reg;
            // sums for B3 and X3
            j_b3n_reg  <= {ac1[29:0], 2'b00} + asr(i_pb2_reg, 11) + i_x2a_reg + 32'd2;
            j_x3s_reg  <= i_x1c_reg + asr(i_pb1_reg, 16) + 32'd2;
            j_t_reg    <= i_t_reg;
            j_up_reg   <= i_up_reg;
            j_flt_reg  <= i_flt_reg;
            // B3 truncates toward zero
            k_b3_reg   <= asr(b3_sum, 2);
            k_x3p_reg  <= asr(j_x3s_reg, 2) + K_X3_OFS;
            k_t_reg    <= j_t_reg;
            k_up_reg   <= j_up_reg;
            k_flt_reg  <= j_flt_reg;
            // B4 product, pressure difference
            l_b4p_reg  <= ac4 * k_x3p_reg;
            l_diff_reg <= {16'd0, k_up_reg} - k_b3_reg;
            l_t_reg    <= k_t_reg;
            l_flt_reg  <= k_flt_reg;
            // B4 and B7
            m_b4_reg   <= {15'd0, l_b4p_reg[31:15]};
            m_b7_reg   <= l_diff_reg * K_B7_MUL;
            m_t_reg    <= l_t_reg;
            m_flt_reg  <= l_flt_reg;
            // pick numerator for the unsigned divide
            n_dbl_reg  <= m_b7_reg[31];
            n_num_reg  <= m_b7_reg[31] ? m_b7_reg : {m_b7_reg[30:0], 1'b0};
            n_b4_reg   <= m_b4_reg;
            n_t_reg    <= m_t_reg;
            n_flt_reg  <= m_flt_reg || (m_b4_reg == 32'd0);
        end
    end

    logic             dv2_valid;
    logic [31:0]      dv2_quo;
    logic [SB2_W-1:0] dv2_sb;

    bpc_div #(.W(WORD_W), .SB_W(SB2_W)) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n_v_reg),
        .num      (n_num_reg),
        .den      (n_b4_reg),
        .sb_in    ({n_t_reg, n_flt_reg, n_dbl_reg}),
        .out_valid(dv2_valid),
        .quo      (dv2_quo),
        .sb_out   (dv2_sb)
    );

    logic [15:0] dv2_t;
    logic        dv2_flt, dv2_dbl;
    assign {dv2_t, dv2_flt, dv2_dbl} = dv2_sb;

    // ---------------- pressure correction ----------------
    logic o_v_reg, p_v_reg, q_v_reg, r_v_reg, u_v_reg, w_v_reg;
    logic [31:0] o_p_reg, p_p_reg, p_s_reg, q_sq_reg, q_m2_reg, q_p_reg;
    logic [31:0] r_m1_reg, r_x2_reg, r_p_reg, u_sum_reg, u_p_reg, w_pf_reg;
    logic [15:0] o_t_reg, p_t_reg, q_t_reg, r_t_reg, u_t_reg, w_t_reg;
    logic o_flt_reg, p_flt_reg, q_flt_reg, r_flt_reg, u_flt_reg, w_flt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0; p_v_reg <= 1'b0; q_v_reg <= 1'b0;
            r_v_reg <= 1'b0; u_v_reg <= 1'b0; w_v_reg <= 1'b0;
        end
        else if (en)
        begin
            o_v_reg <= dv2_valid;
            p_v_reg <= o_v_reg;
            q_v_reg <= p_v_reg;
            r_v_reg <= q_v_reg;
            u_v_reg <= r_v_reg;
            w_v_reg <= u_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // double the quotient when the numerator was not doubled
            o_p_reg   <= dv2_dbl ? {dv2_quo[30:0], 1'b0} : dv2_quo;
            o_t_reg   <= dv2_t;
            o_flt_reg <= dv2_flt;
            // p >> 8
            p_p_reg   <= o_p_reg;
            p_s_reg   <= asr(o_p_reg, 8);
            p_t_reg   <= o_t_reg;
            p_flt_reg <= o_flt_reg;
            // square and linear term
            q_sq_reg  <= p_s_reg * p_s_reg;
            q_m2_reg  <= K_P_LIN * p_p_reg;
            q_p_reg   <= p_p_reg;
            q_t_reg   <= p_t_reg;
            q_flt_reg <= p_flt_reg;
            // quadratic term
            r_m1_reg  <= q_sq_reg * K_P_SQ_MUL;
            r_x2_reg  <= asr(q_m2_reg, 16);
            r_p_reg   <= q_p_reg;
            r_t_reg   <= q_t_reg;
            r_flt_reg <= q_flt_reg;
            // correction sum
            u_sum_reg <= asr(r_m1_reg, 16) + r_x2_reg + K_P_OFS;
            u_p_reg   <= r_p_reg;
            u_t_reg   <= r_t_reg;
            u_flt_reg <= r_flt_reg;
            // final pressure
            w_pf_reg  <= u_p_reg + asr(u_sum_reg, 4);
            w_t_reg   <= u_t_reg;
            w_flt_reg <= u_flt_reg;
        end
    end

    // ---------------- output register ----------------
    logic [16:0] p_sat;
    always_comb
    begin
        if ($signed(w_pf_reg) > P_MAX)
            p_sat = P_MAX[16:0];
        else if (w_pf_reg[31])
            p_sat = '0;
        else
            p_sat = w_pf_reg[16:0];
    end

    logic [15:0] out_t_reg;
    logic [16:0] out_p_reg;
    logic        out_flt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= w_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_t_reg   <= w_flt_reg ? 16'd0 : w_t_reg;
            out_p_reg   <= w_flt_reg ? 17'd0 : p_sat;
            out_flt_reg <= w_flt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_p_reg, out_t_reg};
    assign m_tuser  = out_flt_reg;

    // ---------------- assertions ----------------
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[32:0] == 33'd0)
        else $error("faulted beat carries nonzero results");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> a_v_reg)
        else $error("accepted beat did not enter the pipe");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv1_valid) && $stable(dv2_valid))
        else $error("divider moved during a stall");

endmodule

`default_nettype wire
